// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/appe_pkg.sv -----
// Types, register indexes and the residual function of the planar encoder.
// Used by appe_scan, the top level and the checker; no dependencies.
`timescale 1ns / 1ps

package appe_pkg;

  localparam int CFG_W     = 12;
  localparam int REG_IDX_W = 2;
  localparam int ADDR_W    = 24;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HAS_ALPHA    = 2'd2;

  typedef struct packed {
    logic [7:0] pixel_blue;
    logic [7:0] pixel_green;
    logic [7:0] pixel_red;
    logic [7:0] pixel_alpha;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  resid_blue;
    logic [7:0]  resid_green;
    logic [7:0]  resid_red;
    logic [7:0]  resid_alpha;
    logic [21:0] addr_blue;
    logic [22:0] addr_green;
    logic [23:0] addr_red;
    logic [21:0] addr_alpha;
    logic        alpha_valid;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] image_width;
    logic [CFG_W-1:0] image_height;
    logic             has_alpha;
  } cfg_t;

  typedef enum logic [1:0] {
    PRED_RAW,   // first pixel of the frame
    PRED_LEFT,  // rest of the top row
    PRED_UP,    // left column below the top row
    PRED_AVG    // interior
  } pred_mode_t;

  typedef struct packed {
    pred_mode_t        mode;
    logic [CFG_W-1:0]  x;
    logic [ADDR_W-1:0] off;   // offset inside a color plane
    logic [ADDR_W-1:0] aoff;  // offset inside the alpha buffer
  } scan_t;

  function automatic logic [7:0] resid(pred_mode_t mode, logic [7:0] cur,
                                       logic [7:0] up, logic [7:0] left);
    logic [8:0] sum;
    logic [7:0] r;
    sum = {1'b0, up} + {1'b0, left};
    unique case (mode)
      PRED_RAW:  r = cur;
      PRED_LEFT: r = left - cur;
      PRED_UP:   r = up - cur;
      PRED_AVG:  r = sum[8:1] - cur;
      default:   r = cur;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/appe_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module appe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read of an address written in the same cycle returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/appe_scan.sv -----
// Raster position tracking and plane address generation.
// Depends on appe_pkg.
`timescale 1ns / 1ps

module appe_scan import appe_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              restart,
  input  logic              advance,
  output scan_t             scan,
  output logic [ADDR_W-1:0] plane
);

  logic [CFG_W-1:0]     w_eff;
  logic [CFG_W-1:0]     h_eff;
  logic [CFG_W:0]       w_inc;
  logic [CFG_W:0]       h_inc;
  logic [CFG_W:0]       w_even;
  logic [CFG_W:0]       h_even;
  logic [2*CFG_W+1:0]   plane_prod;
  logic [CFG_W-1:0]     col;
  logic [CFG_W-1:0]     row;
  logic [ADDR_W-1:0]    pair_base;
  logic [ADDR_W-1:0]    line_base;
  logic                 last_col;
  logic                 last_row;

  always_comb begin
    priority if (cfg.image_width == '0) w_eff = CFG_W'(1);
    else if (int'(cfg.image_width) > MAX_WIDTH) w_eff = CFG_W'(MAX_WIDTH);
    else w_eff = cfg.image_width;

    priority if (cfg.image_height == '0) h_eff = CFG_W'(1);
    else if (int'(cfg.image_height) > MAX_HEIGHT) h_eff = CFG_W'(MAX_HEIGHT);
    else h_eff = cfg.image_height;

    w_inc      = {1'b0, w_eff} + 1'b1;
    h_inc      = {1'b0, h_eff} + 1'b1;
    w_even     = {w_inc[CFG_W:1], 1'b0};
    h_even     = {h_inc[CFG_W:1], 1'b0};
    plane_prod = w_even * h_even;

    last_col = ({1'b0, col} + 1'b1) >= {1'b0, w_eff};
    last_row = ({1'b0, row} + 1'b1) >= {1'b0, h_eff};
  end

  always_ff @(posedge clk) begin
    plane <= plane_prod[ADDR_W-1:0];
    if (rst || restart) begin
      col       <= '0;
      row       <= '0;
      pair_base <= '0;
      line_base <= '0;
    end else if (advance) begin
      if (!last_col) begin
        col <= col + 1'b1;
      end else begin
        col <= '0;
        if (last_row) begin
          row       <= '0;
          pair_base <= '0;
          line_base <= '0;
        end else begin
          row       <= row + 1'b1;
          line_base <= line_base + ADDR_W'(w_even);
          // odd row done: next row pair starts
          if (row[0]) begin
            pair_base <= pair_base + ADDR_W'({w_even, 1'b0});
          end
        end
      end
    end
  end

  always_comb begin
    priority if (row == '0 && col == '0) scan.mode = PRED_RAW;
    else if (row == '0) scan.mode = PRED_LEFT;
    else if (col == '0) scan.mode = PRED_UP;
    else scan.mode = PRED_AVG;
    scan.x    = col;
    scan.off  = pair_base + ADDR_W'({col, 1'b0}) + ADDR_W'(row[0]);
    scan.aoff = line_base + ADDR_W'(col);
  end

endmodule

// ----- sv/average_predictor_planar_encoder_core.sv -----
// Average-prediction residual encoder: top level with line buffer and pipeline.
// Depends on appe_pkg, appe_ram and appe_scan.
//
// Usage:
//   Pixels come in raster order on pix (pix_valid / pix_stall). Each transfer
//   yields exactly one result on res (res_valid / res_stall): four residuals,
//   their plane addresses and the alpha flag.
//   A pixel transfer is registered in the middle stage, then in the output register.
//   Throughput is one pixel per cycle while res_stall is low, set by the single line-buffer RAM that
//   does one read and one write of the same column per pixel.
//   Configuration is written through cfg_we / cfg_index / cfg_data while the
//   block is idle; a write to any defined register restarts the frame at the
//   top-left pixel.
//   Reset empties the pipeline and sets width 1, height 1, no alpha. The line
//   buffer is not cleared; every entry is written in a row before it is read.
//   While res_stall is high the result holds; one more pixel is taken into the
//   middle stage, after which pix_stall goes high until the result moves.
`timescale 1ns / 1ps

module average_predictor_planar_encoder_core import appe_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  pixel_t               pix,
  output logic                 res_valid,
  input  logic                 res_stall,
  output result_t              res,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  cfg_t              cfg;
  logic              restart;
  scan_t             scan;
  logic [ADDR_W-1:0] plane;
  logic              take;
  logic              s1_move;
  logic              s1_valid;
  pixel_t            s1_cur;
  pixel_t            s1_left;
  scan_t             s1_scan;
  pixel_t            left_pixel;
  logic [31:0]       up_word;
  pixel_t            up;
  logic [ADDR_W-1:0] green_sum;
  logic [ADDR_W-1:0] red_sum;

  // configuration registers
  always_comb begin
    unique case (cfg_index)
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_HAS_ALPHA: restart = cfg_we;
      default: restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= CFG_W'(1);
      cfg.image_height <= CFG_W'(1);
      cfg.has_alpha    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        REG_HAS_ALPHA:    cfg.has_alpha    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake: middle stage advances when the output register is free
  assign s1_move   = s1_valid && (!res_valid || !res_stall);
  assign pix_stall = s1_valid && !s1_move;
  assign take      = pix_valid && !pix_stall;

  appe_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .restart(restart),
    .advance(take),
    .scan   (scan),
    .plane  (plane)
  );

  // line buffer: read the row above and overwrite it with this pixel
  appe_ram #(
    .WIDTH($bits(pixel_t)),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (take),
    .waddr(AW'(scan.x)),
    .wdata(pix),
    .re   (take),
    .raddr(AW'(scan.x)),
    .rdata(up_word)
  );

  assign up = pixel_t'(up_word);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (take) begin
      s1_cur  <= pix;
      s1_left <= left_pixel;
      s1_scan <= scan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      left_pixel <= '0;
    end else if (take) begin
      left_pixel <= pix;
    end
  end

  assign green_sum = s1_scan.off + plane;
  assign red_sum   = s1_scan.off + {plane[ADDR_W-2:0], 1'b0};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_move) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (s1_move) begin
      res.resid_blue  <= resid(s1_scan.mode, s1_cur.pixel_blue, up.pixel_blue,
                               s1_left.pixel_blue);
      res.resid_green <= resid(s1_scan.mode, s1_cur.pixel_green, up.pixel_green,
                               s1_left.pixel_green);
      res.resid_red   <= resid(s1_scan.mode, s1_cur.pixel_red, up.pixel_red,
                               s1_left.pixel_red);
      res.resid_alpha <= cfg.has_alpha ?
                         resid(s1_scan.mode, s1_cur.pixel_alpha, up.pixel_alpha,
                               s1_left.pixel_alpha) : 8'd0;
      res.addr_blue   <= s1_scan.off[21:0];
      res.addr_green  <= green_sum[22:0];
      res.addr_red    <= red_sum[23:0];
      res.addr_alpha  <= cfg.has_alpha ? s1_scan.aoff[21:0] : 22'd0;
      res.alpha_valid <= cfg.has_alpha;
    end
  end

endmodule

// ----- sv/appe_checker.sv -----
// Port-level checks of the planar encoder, bound to the top level.
// Depends on appe_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module appe_checker import appe_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    pix_valid,
  input logic    pix_stall,
  input logic    res_valid,
  input logic    res_stall,
  input result_t res
);

  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid, "result dropped while stalled")
  `ASSERT_NEXT(a_res_stable, clk, rst, res_valid && res_stall, $stable(res), "stalled result changed")
  `ASSERT_IMPLY(a_alpha_off, clk, rst, res_valid && !res.alpha_valid, res.resid_alpha == 8'd0 && res.addr_alpha == 22'd0, "alpha fields set without alpha")
  `ASSERT_IMPLY(a_res_origin, clk, rst, $rose(res_valid), $past(pix_valid && !pix_stall, 2), "result without a pixel two cycles before")

endmodule

bind average_predictor_planar_encoder_core appe_checker u_appe_checker (
  .clk      (clk),
  .rst      (rst),
  .pix_valid(pix_valid),
  .pix_stall(pix_stall),
  .res_valid(res_valid),
  .res_stall(res_stall),
  .res      (res)
);

// ----- tb/tb_average_predictor_planar_encoder_core.sv -----
// Self-checking bench for average_predictor_planar_encoder_core: directed and random pixel frames
// through a valid/stall driver, results checked against a built-in residual predictor.
// Depends on appe_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_average_predictor_planar_encoder_core;
  import appe_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int MAX_W          = 2048;
  localparam int MAX_H          = 2048;
  localparam int PIPE_LATENCY   = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PIXELS  = 1050;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pix_valid = 1'b0;
  logic                 pix_stall;
  pixel_t               pix = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  result_t              res;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;

  average_predictor_planar_encoder_core #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: mirror of the line buffer, left pixel, scan position, regs
  // ---------------------------------------------------------------------------
  pixel_t           line_buf [0:MAX_W-1];
  pixel_t           left_px;
  int unsigned      scan_col;
  int unsigned      scan_row;
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic             frame_alpha;

  pixel_t  pixels_to_send [$];
  result_t residuals_due [$];

  int unsigned pixels_queued   = 0;
  int unsigned pixels_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned settings_used   = 0;
  int unsigned idle_cycles     = 0;

  function automatic int unsigned eff_dim(logic [CFG_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic result_t encode_pixel(pixel_t cur);
    result_t           r;
    pred_mode_t        mode;
    int unsigned       w, h, x, y, c;
    longint unsigned   w_even, h_even, plane, off, green_off, red_off, alpha_off;
    logic [7:0]        now_b [4];
    logic [7:0]        up_b [4];
    logic [7:0]        left_b [4];
    logic [7:0]        res_b [4];
    logic [8:0]        avg9;
    pixel_t            up;
    w = eff_dim(frame_width, MAX_W);
    h = eff_dim(frame_height, MAX_H);
    x = (scan_col >= w) ? w - 1 : scan_col;
    y = (scan_row >= h) ? h - 1 : scan_row;
    up = line_buf[x];
    now_b  = '{cur.pixel_blue, cur.pixel_green, cur.pixel_red, cur.pixel_alpha};
    up_b   = '{up.pixel_blue, up.pixel_green, up.pixel_red, up.pixel_alpha};
    left_b = '{left_px.pixel_blue, left_px.pixel_green, left_px.pixel_red,
               left_px.pixel_alpha};
    if (x == 0 && y == 0) mode = PRED_RAW;
    else if (y == 0) mode = PRED_LEFT;
    else if (x == 0) mode = PRED_UP;
    else mode = PRED_AVG;
    for (c = 0; c < 4; c++) begin
      avg9 = {1'b0, up_b[c]} + {1'b0, left_b[c]};
      case (mode)
        PRED_RAW:  res_b[c] = now_b[c];
        PRED_LEFT: res_b[c] = left_b[c] - now_b[c];
        PRED_UP:   res_b[c] = up_b[c] - now_b[c];
        default:   res_b[c] = avg9[8:1] - now_b[c];
      endcase
    end
    w_even = (w + 1) & ~32'd1;
    h_even = (h + 1) & ~32'd1;
    plane = w_even * h_even;
    off = (y >> 1) * 2 * w_even + 2 * x + (y & 1);
    green_off = off + plane;
    red_off = off + 2 * plane;
    alpha_off = y * w_even + x;
    r.resid_blue  = res_b[0];
    r.resid_green = res_b[1];
    r.resid_red   = res_b[2];
    r.resid_alpha = frame_alpha ? res_b[3] : 8'd0;
    r.addr_blue   = off[21:0];
    r.addr_green  = green_off[22:0];
    r.addr_red    = red_off[23:0];
    r.addr_alpha  = frame_alpha ? alpha_off[21:0] : 22'd0;
    r.alpha_valid = frame_alpha;
    line_buf[x] = cur;
    left_px = cur;
    if (x + 1 >= w) begin
      scan_col = 0;
      scan_row = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      scan_col = x + 1;
      scan_row = y;
    end
    return r;
  endfunction

  // Register writes update the predictor on the same edge the block takes them.
  always @(posedge clk) begin
    if (rst) begin
      frame_width  = CFG_W'(1);
      frame_height = CFG_W'(1);
      frame_alpha  = 1'b0;
      left_px      = '0;
      scan_col     = 0;
      scan_row     = 0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  frame_width = cfg_data;
        REG_IMAGE_HEIGHT: frame_height = cfg_data;
        REG_HAS_ALPHA:    frame_alpha = cfg_data[0];
        default:          ;
      endcase
      // an undefined index leaves the frame position alone
      if (cfg_index != REG_UNUSED) begin
        left_px  = '0;
        scan_col = 0;
        scan_row = 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idle pattern: mostly short gaps, a few long ones, quiet stretches with none
  // ---------------------------------------------------------------------------
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Driver: holds the payload while stalled, inserts gaps between transfers.
  bit          send_quiet = 1'b0;
  int unsigned send_gap   = 0;

  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (pix_valid && !pix_stall) begin
        residuals_due.push_back(encode_pixel(pix));
        pixels_accepted++;
      end
      if (pix_valid && pix_stall) begin
        // stalled transfer keeps its payload
      end else if (send_gap != 0) begin
        send_gap--;
        pix_valid <= 1'b0;
      end else if (pixels_to_send.size() != 0) begin
        pix <= pixels_to_send.pop_front();
        pix_valid <= 1'b1;
        if ($urandom_range(0, 63) == 0) send_quiet = !send_quiet;
        send_gap = send_quiet ? 0 : idle_len();
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer and drives a random stall.
  bit          recv_quiet = 1'b0;
  int unsigned recv_hold  = 0;

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (residuals_due.size() == 0) begin
        $error("result transfer with no pixel outstanding");
        mismatches++;
      end else begin
        want = residuals_due.pop_front();
        check_field("resid_blue",  want.resid_blue,  res.resid_blue);
        check_field("resid_green", want.resid_green, res.resid_green);
        check_field("resid_red",   want.resid_red,   res.resid_red);
        check_field("resid_alpha", want.resid_alpha, res.resid_alpha);
        check_field("addr_blue",   want.addr_blue,   res.addr_blue);
        check_field("addr_green",  want.addr_green,  res.addr_green);
        check_field("addr_red",    want.addr_red,    res.addr_red);
        check_field("addr_alpha",  want.addr_alpha,  res.addr_alpha);
        check_field("alpha_valid", want.alpha_valid, res.alpha_valid);
        results_checked++;
      end
    end
    if (rst) begin
      res_stall <= 1'b0;
    end else if (recv_hold != 0) begin
      recv_hold--;
      res_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) recv_quiet = !recv_quiet;
      recv_hold = recv_quiet ? 0 : idle_len();
      res_stall <= 1'b0;
    end
  end

  // Watchdog: no transfer and no register write for too long means a hang.
  always @(posedge clk) begin
    if (rst || cfg_we || (pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic [7:0] a);
    pixel_t p;
    p.pixel_blue  = b;
    p.pixel_green = g;
    p.pixel_red   = r;
    p.pixel_alpha = a;
    pixels_to_send.push_back(p);
    pixels_queued++;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic program_frame(logic [CFG_W-1:0] width, logic [CFG_W-1:0] height,
                               logic alpha);
    write_reg(REG_IMAGE_WIDTH, width);
    write_reg(REG_IMAGE_HEIGHT, height);
    write_reg(REG_HAS_ALPHA, {{(CFG_W-1){1'b0}}, alpha});
    settings_used++;
  endtask

  // Block is idle once every queued pixel went in and every result came out.
  task automatic wait_drained();
    do @(negedge clk);
    while (!(pixels_to_send.size() == 0 && pixels_accepted == pixels_queued &&
             residuals_due.size() == 0));
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return CFG_W'($urandom_range(1, 8));
    if (r < 85) return CFG_W'($urandom_range(9, 48));
    if (r < 91) return '0;
    if (r < 97) return CFG_W'($urandom_range(MAX_W - 8, MAX_W));
    return CFG_W'($urandom_range(MAX_W + 1, 4095));
  endfunction

  initial begin
    int unsigned      random_pixels, phase, frame, cap, n, half, k;
    logic [CFG_W-1:0] cur_w, cur_h;
    bit               wrote;
    random_pixels = 0;
    phase = 0;
    cur_w = CFG_W'(1);
    cur_h = CFG_W'(1);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one-pixel frame, every pixel is a frame start
    queue_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'h5A, 8'hA5, 8'h0F, 8'hF0);
    wait_drained();

    // 3x2 with alpha: raw, left, up and average paths
    program_frame(12'd3, 12'd2, 1'b1);
    queue_pixel(8'hFF, 8'h00, 8'h80, 8'h01);
    queue_pixel(8'h00, 8'hFF, 8'h01, 8'h80);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    wait_drained();
    // undefined register index must not restart the frame; the next two pixels end it and wrap
    write_reg(REG_UNUSED, 12'hFFF);
    queue_pixel(8'h01, 8'hFE, 8'h7F, 8'h80);
    queue_pixel(8'hC8, 8'h37, 8'h00, 8'hFF);
    wait_drained();

    // zero size acts as one, alpha byte ignored without alpha
    program_frame(12'd0, 12'd0, 1'b0);
    queue_pixel(8'h12, 8'h34, 8'h56, 8'hFF);
    queue_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
    queue_pixel(8'h00, 8'hFF, 8'h00, 8'hFF);
    wait_drained();

    // oversize saturates to the maximum frame
    program_frame(12'hFFF, 12'hFFF, 1'b1);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    queue_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
    queue_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
    wait_drained();
    write_reg(REG_HAS_ALPHA, 12'd0);
    queue_pixel(8'h80, 8'h7F, 8'h01, 8'hFE);
    queue_pixel(8'h7F, 8'h80, 8'hFE, 8'h01);
    wait_drained();
    cur_w = 12'hFFF;
    cur_h = 12'hFFF;

    // random frames; first one is wide enough to cover long interior rows
    while (random_pixels < RANDOM_PIXELS) begin
      if (phase == 0) begin
        cur_w = 12'd70;
        cur_h = 12'd3;
        program_frame(cur_w, cur_h, 1'($urandom_range(0, 1)));
      end else begin
        wrote = 1'b0;
        if ($urandom_range(0, 2) != 0) begin
          cur_w = pick_dim();
          write_reg(REG_IMAGE_WIDTH, cur_w);
          wrote = 1'b1;
        end
        if ($urandom_range(0, 2) != 0) begin
          cur_h = pick_dim();
          write_reg(REG_IMAGE_HEIGHT, cur_h);
          wrote = 1'b1;
        end
        if ($urandom_range(0, 2) != 0 || !wrote) begin
          write_reg(REG_HAS_ALPHA, $urandom_range(0, 1) ? 12'd1 : 12'hFFE);
        end
        if ($urandom_range(0, 9) == 0) begin
          write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 4095)));
        end
        settings_used++;
      end
      frame = eff_dim(cur_w, MAX_W) * eff_dim(cur_h, MAX_H);
      cap = (phase == 0) ? frame : ((frame * 3 < 160) ? frame * 3 : 160);
      n = (phase == 0) ? frame : $urandom_range(1, cap);
      half = ($urandom_range(0, 3) == 0) ? n / 2 : n;
      for (k = 0; k < n; k++) begin
        // occasionally let the block run dry mid-frame
        if (k == half && k != 0) begin
          wait_drained();
          if ($urandom_range(0, 1) != 0) begin
            write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 4095)));
          end
        end
        queue_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte());
      end
      random_pixels += n;
      phase++;
      wait_drained();
    end

    wait_drained();
    if (residuals_due.size() != 0) begin
      $error("%0d results never arrived", residuals_due.size());
      mismatches++;
    end
    $display("Sent %0d pixels over %0d register settings (sizes 0..4095, alpha on/off).",
             pixels_accepted, settings_used);
    $display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
